### hw/rtl/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_REVERSE    = 3'd4,
    FUNC_CLEAR      = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] front_word;
    logic [63:0] back_word;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
    logic        refused;
  } out_item_t;

  // (h + k) mod DEPTH, valid for h < DEPTH and k <= DEPTH
  function automatic idx_t ring_add(idx_t h, cnt_t k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return idx_t'(s);
  endfunction

  function automatic idx_t ring_inc(idx_t h);
    return (h == idx_t'(DEPTH - 1)) ? '0 : h + idx_t'(1);
  endfunction

  function automatic idx_t ring_dec(idx_t h);
    return (h == '0) ? idx_t'(DEPTH - 1) : h - idx_t'(1);
  endfunction

endpackage

### hw/rtl/double_ended_queue_core.sv
// Results are registered and become valid in the cycle after accept.
// Throughput: one transaction per cycle unless stalled; the ring store has
// one write port and two registered read ports, all used in the accept cycle.
// Reset: asynchronous, active low; the deque comes out empty, head at slot 0,
// normal order. Store contents are not cleared and need no clearing pass.
module double_ended_queue_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  deq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output deq_pkg::out_item_t out_item_o
);

  deq_pkg::word_t ring_q [deq_pkg::DEPTH];

  deq_pkg::idx_t  head_q, head_d;
  deq_pkg::cnt_t  cnt_q, cnt_d;
  logic           rev_q, rev_d;
  logic           valid_q;
  logic           refused_q, refused_d;
  deq_pkg::word_t first_q, last_q;

  logic           in_acc;
  logic           wr_en;
  deq_pkg::idx_t  wr_addr;
  deq_pkg::word_t wr_data;
  deq_pkg::idx_t  rd_first_addr, rd_last_addr;
  logic           is_full, is_empty, at_first;
  deq_pkg::func_e func;

  assign in_stall_o = valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign func     = deq_pkg::func_e'(in_item_i.func);
  assign is_full  = (cnt_q == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign is_empty = (cnt_q == '0);
  assign wr_data  = deq_pkg::word_t'(in_item_i.data_word);

  always_comb begin
    head_d    = head_q;
    cnt_d     = cnt_q;
    rev_d     = rev_q;
    refused_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = deq_pkg::ring_add(head_q, cnt_q);
    at_first  = 1'b0;
    case (func)
      deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
        at_first = ((func == deq_pkg::FUNC_PUSH_FRONT) == !rev_q);
        if (is_full) begin
          refused_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + deq_pkg::cnt_t'(1);
          if (at_first) begin
            head_d  = deq_pkg::ring_dec(head_q);
            wr_addr = head_d;
          end
        end
      end
      deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
        at_first = ((func == deq_pkg::FUNC_POP_FRONT) == !rev_q);
        if (is_empty) begin
          refused_d = 1'b1;
        end else begin
          cnt_d = cnt_q - deq_pkg::cnt_t'(1);
          if (at_first) begin
            head_d = deq_pkg::ring_inc(head_q);
          end
        end
      end
      deq_pkg::FUNC_REVERSE: begin
        rev_d = !rev_q;
      end
      deq_pkg::FUNC_CLEAR: begin
        head_d = '0;
        cnt_d  = '0;
        rev_d  = 1'b0;
      end
      default: begin
      end
    endcase
    rd_first_addr = head_d;
    rd_last_addr  = deq_pkg::ring_add(head_d, cnt_d - deq_pkg::cnt_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      cnt_q     <= '0;
      rev_q     <= 1'b0;
      valid_q   <= 1'b0;
      refused_q <= 1'b0;
    end else begin
      if (in_acc) begin
        head_q    <= head_d;
        cnt_q     <= cnt_d;
        rev_q     <= rev_d;
        refused_q <= refused_d;
        valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // ring store: one write port, two read ports with write-first bypass
  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      ring_q[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      first_q <= (wr_en && (rd_first_addr == wr_addr)) ? wr_data : ring_q[rd_first_addr];
      last_q  <= (wr_en && (rd_last_addr == wr_addr)) ? wr_data : ring_q[rd_last_addr];
    end
  end

  logic out_empty;
  assign out_empty = (cnt_q == '0);

  always_comb begin
    out_item_o             = '0;
    out_item_o.entry_count = 5'(cnt_q);
    out_item_o.is_empty    = out_empty;
    out_item_o.is_full     = (cnt_q == deq_pkg::cnt_t'(deq_pkg::DEPTH));
    out_item_o.refused     = refused_q;
    if (!out_empty) begin
      out_item_o.front_word = 64'(rev_q ? last_q : first_q);
      out_item_o.back_word  = 64'(rev_q ? first_q : last_q);
    end
  end

  assign out_valid_o = valid_q;

endmodule

### hw/rtl/deq_checker.sv
module deq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input deq_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input deq_pkg::out_item_t out_item_o
);

  // every accepted transaction yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("no result after accepted transaction");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.entry_count <= 5'(deq_pkg::DEPTH)))
    else $error("count beyond depth");

  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_empty) |->
      ((out_item_o.front_word == '0) && (out_item_o.back_word == '0)
       && !out_item_o.is_full))
    else $error("empty deque shows words");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
